// ===== rtl/sus_pkg.sv =====
`timescale 1ns / 1ps
// sus_pkg: shared widths, operation and status codes, control structs of the sorted set
package sus_pkg;

  localparam int DATA_W           = 32;
  localparam int OP_W             = 2;
  localparam int ST_W             = 2;
  localparam int CNT_OUT_W        = 5;
  localparam int CAPACITY_DEFAULT = 16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  localparam logic [1:0] SRC_VALUE = 2'd0;
  localparam logic [1:0] SRC_CARRY = 2'd1;
  localparam logic [1:0] SRC_RDATA = 2'd2;

  typedef struct packed {
    logic            start;
    logic            step;
    logic            wr_en;
    logic [1:0]      wr_src;
    logic            wr_prev;
    logic            carry_load;
    logic            flag_set;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            cnt_clr;
    logic            rd_first;
    logic            cap_small;
    logic            out_load;
    logic [ST_W-1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            at_end;
    logic            rd_eq;
    logic            rd_gt;
    logic            flag;
    logic            full;
    logic            out_busy;
  } stat_t;

endpackage

// ===== rtl/sus_ifs.sv =====
`timescale 1ns / 1ps
// sus_ifs: request and response channel interfaces of the sorted set
interface sus_req_if;
  logic                                valid;
  logic                                ready;
  logic        [sus_pkg::OP_W-1:0]     operation;
  logic signed [sus_pkg::DATA_W-1:0]   value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface sus_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [sus_pkg::ST_W-1:0]     status;
  logic        [sus_pkg::CNT_OUT_W-1:0] entry_count;
  logic signed [sus_pkg::DATA_W-1:0]   smallest;
  logic signed [sus_pkg::DATA_W-1:0]   largest;

  modport source (output valid, output status, output entry_count, output smallest,
                  output largest, input ready);
  modport sink   (input valid, input status, input entry_count, input smallest,
                  input largest, output ready);
endinterface

// ===== rtl/sus_ctrl.sv =====
`timescale 1ns / 1ps
// sus_ctrl: state machine that sequences scans, shifts and result capture
module sus_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  sus_pkg::stat_t stat,
  output sus_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_FIRST,
    S_LAST,
    S_CAPT
  } state_t;

  state_t                   state;
  state_t                   state_next;
  logic [sus_pkg::ST_W-1:0] status;
  logic [sus_pkg::ST_W-1:0] status_next;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    status_next = status;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.rd_first = 1'b1;
        status_next  = sus_pkg::ST_OK;
        state_next   = S_FIRST;
        case (stat.op)
          sus_pkg::OP_INSERT: begin
            if (stat.full) begin
              status_next = sus_pkg::ST_FULL;
            end else begin
              state_next = S_SCAN;
            end
          end
          sus_pkg::OP_DELETE: begin
            state_next = S_SCAN;
          end
          sus_pkg::OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.op == sus_pkg::OP_INSERT) begin
          if (stat.at_end) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_src  = stat.flag ? sus_pkg::SRC_CARRY : sus_pkg::SRC_VALUE;
            cmd.cnt_inc = 1'b1;
            state_next  = S_FIRST;
          end else if (stat.flag) begin
            // ripple the displaced entry one place up
            cmd.wr_en      = 1'b1;
            cmd.wr_src     = sus_pkg::SRC_CARRY;
            cmd.carry_load = 1'b1;
          end else if (stat.rd_eq) begin
            status_next = sus_pkg::ST_DUPLICATE;
            state_next  = S_FIRST;
          end else if (stat.rd_gt) begin
            cmd.wr_en      = 1'b1;
            cmd.wr_src     = sus_pkg::SRC_VALUE;
            cmd.carry_load = 1'b1;
            cmd.flag_set   = 1'b1;
          end
        end else begin
          if (stat.at_end) begin
            if (stat.flag) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              status_next = sus_pkg::ST_NOT_FOUND;
            end
            state_next = S_FIRST;
          end else if (stat.flag) begin
            // close the gap left by the removed entry
            cmd.wr_en   = 1'b1;
            cmd.wr_src  = sus_pkg::SRC_RDATA;
            cmd.wr_prev = 1'b1;
          end else if (stat.rd_eq) begin
            cmd.flag_set = 1'b1;
          end
        end
      end
      S_FIRST: begin
        cmd.rd_first = 1'b1;
        state_next   = S_LAST;
      end
      S_LAST: begin
        cmd.cap_small = 1'b1;
        state_next    = S_CAPT;
      end
      S_CAPT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.out_status = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      status <= sus_pkg::ST_OK;
    end else begin
      state  <= state_next;
      status <= status_next;
    end
  end

  assign req_ready = (state == S_IDLE) && !rst;

endmodule

// ===== rtl/sus_dp.sv =====
`timescale 1ns / 1ps
// sus_dp: value store, scan index, count and response register of the sorted set
module sus_dp #(
  parameter int CAPACITY = sus_pkg::CAPACITY_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic        [sus_pkg::OP_W-1:0]       operation,
  input  logic signed [sus_pkg::DATA_W-1:0]     value,
  input  sus_pkg::cmd_t                         cmd,
  output sus_pkg::stat_t                        stat,
  output logic                                  rsp_valid,
  input  logic                                  rsp_ready,
  output logic        [sus_pkg::ST_W-1:0]       rsp_status,
  output logic        [sus_pkg::CNT_OUT_W-1:0]  rsp_count,
  output logic signed [sus_pkg::DATA_W-1:0]     rsp_small,
  output logic signed [sus_pkg::DATA_W-1:0]     rsp_large
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic        [sus_pkg::DATA_W-1:0]    mem [CAPACITY];
  logic        [sus_pkg::DATA_W-1:0]    rdata;
  logic        [sus_pkg::OP_W-1:0]      op_q;
  logic signed [sus_pkg::DATA_W-1:0]    value_q;
  logic        [sus_pkg::DATA_W-1:0]    carry;
  logic        [sus_pkg::DATA_W-1:0]    small_q;
  logic        [CW-1:0]                 idx;
  logic        [CW-1:0]                 count;
  logic                                 flag;

  logic        [CW-1:0]                 idx_inc;
  logic        [CW-1:0]                 idx_dec;
  logic        [CW-1:0]                 count_last;
  logic        [AW-1:0]                 rd_addr;
  logic        [AW-1:0]                 wr_addr;
  logic        [sus_pkg::DATA_W-1:0]    wr_data;
  logic        [CW+sus_pkg::CNT_OUT_W-1:0] count_ext;

  assign idx_inc    = idx + 1'b1;
  assign idx_dec    = idx - 1'b1;
  assign count_last = count - 1'b1;
  assign count_ext  = {{sus_pkg::CNT_OUT_W{1'b0}}, count};

  always_comb begin
    if (cmd.step) begin
      rd_addr = idx_inc[AW-1:0];
    end else if (cmd.rd_first) begin
      rd_addr = '0;
    end else begin
      rd_addr = count_last[AW-1:0];
    end
  end

  assign wr_addr = cmd.wr_prev ? idx_dec[AW-1:0] : idx[AW-1:0];

  always_comb begin
    case (cmd.wr_src)
      sus_pkg::SRC_VALUE: wr_data = value_q;
      sus_pkg::SRC_CARRY: wr_data = carry;
      sus_pkg::SRC_RDATA: wr_data = rdata;
      default:            wr_data = value_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q    <= operation;
      value_q <= value;
    end
    if (cmd.carry_load) begin
      carry <= rdata;
    end
    if (cmd.cap_small) begin
      small_q <= rdata;
    end
    if (cmd.start) begin
      idx <= '0;
    end else if (cmd.step) begin
      idx <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      flag  <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        count <= '0;
      end else if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count_last;
      end
      if (cmd.start) begin
        flag <= 1'b0;
      end else if (cmd.flag_set) begin
        flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_status <= cmd.out_status;
      rsp_count  <= count_ext[sus_pkg::CNT_OUT_W-1:0];
      if (count == '0) begin
        rsp_small <= '0;
        rsp_large <= '0;
      end else begin
        rsp_small <= small_q;
        rsp_large <= rdata;
      end
    end
  end

  assign stat.op       = op_q;
  assign stat.at_end   = (idx == count);
  assign stat.rd_eq    = (rdata == value_q);
  assign stat.rd_gt    = ($signed(rdata) > value_q);
  assign stat.flag     = flag;
  assign stat.full     = (count >= CW'(CAPACITY));
  assign stat.out_busy = rsp_valid && !rsp_ready;

endmodule

// ===== rtl/sorted_unique_set.sv =====
`timescale 1ns / 1ps
// sorted_unique_set: top level of the sorted set of distinct signed values
//
// req carries one beat per operation: insert, delete or clear, with a value.
// rsp returns one beat per request: status, count after the operation, and
// the smallest and largest values held (both 0 when the set is empty).
// Values live in a single-port-write, single-port-read memory of CAPACITY
// entries; an insert or delete walks it once, one entry per cycle, shifting
// entries as it goes, then reads the first and last entries.
// A full walk covers count + 1 positions, and a duplicate stops an insert
// early; clear, an insert into a full set and unused codes do not walk the
// memory. One request is in flight at a time; the next request beat can be
// taken in the cycle after the response is loaded, not before.
// Reset empties the set at once; memory contents are not cleared.
// The response register holds its beat while rsp.ready is low; the block
// finishes the current item and then waits with req.ready low.
module sorted_unique_set #(
  parameter int CAPACITY = sus_pkg::CAPACITY_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  sus_req_if.sink   req,
  sus_rsp_if.source rsp
);

  sus_pkg::cmd_t  cmd;
  sus_pkg::stat_t stat;

  sus_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sus_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .operation  (req.operation),
    .value      (req.value),
    .cmd        (cmd),
    .stat       (stat),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_count  (rsp.entry_count),
    .rsp_small  (rsp.smallest),
    .rsp_large  (rsp.largest)
  );

endmodule

// ===== rtl/sus_checker.sv =====
`timescale 1ns / 1ps
// sus_checker: port-level assertions of the sorted set, bound to the top level
module sus_checker #(
  parameter int CAPACITY = sus_pkg::CAPACITY_DEFAULT
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 req_valid,
  input logic                                 req_ready,
  input logic                                 rsp_valid,
  input logic        [sus_pkg::ST_W-1:0]      rsp_status,
  input logic        [sus_pkg::CNT_OUT_W-1:0] rsp_count,
  input logic signed [sus_pkg::DATA_W-1:0]    rsp_small,
  input logic signed [sus_pkg::DATA_W-1:0]    rsp_large
);

  localparam logic [sus_pkg::CNT_OUT_W-1:0] CAP_TRUNC = sus_pkg::CNT_OUT_W'(CAPACITY);
  localparam bit COUNT_FITS = (CAPACITY < (1 << sus_pkg::CNT_OUT_W) - 1);

  // one operation in flight: a taken request drops ready
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while an operation is in flight");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == sus_pkg::ST_FULL) |-> (rsp_count == CAP_TRUNC))
    else $error("full reported below capacity");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!COUNT_FITS || rsp_count <= CAP_TRUNC))
    else $error("count above capacity");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && COUNT_FITS && rsp_count == '0) |-> (rsp_small == '0 && rsp_large == '0))
    else $error("empty set reports nonzero bounds");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && COUNT_FITS && rsp_count != '0) |-> (rsp_small <= rsp_large))
    else $error("smallest above largest");

endmodule

bind sorted_unique_set sus_checker #(
  .CAPACITY (CAPACITY)
) u_sus_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_status (rsp.status),
  .rsp_count  (rsp.entry_count),
  .rsp_small  (rsp.smallest),
  .rsp_large  (rsp.largest)
);

// ===== tb/sorted_unique_set_check.sv =====
`timescale 1ns / 1ps
// sorted_unique_set_check: watches both channels, predicts each response beat and compares it
module sorted_unique_set_check #(
  parameter int CAPACITY = sus_pkg::CAPACITY_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  sus_req_if   req,
  sus_rsp_if   rsp,
  output int   mismatches,
  output int   pending
);
  import sus_pkg::*;

  typedef struct packed {
    logic        [ST_W-1:0]      status;
    logic        [CNT_OUT_W-1:0] entry_count;
    logic signed [DATA_W-1:0]    smallest;
    logic signed [DATA_W-1:0]    largest;
  } set_report_t;

  logic signed [DATA_W-1:0] held_values[$];
  set_report_t              awaited_reports[$];

  function automatic set_report_t apply_set_op(input logic [OP_W-1:0] op,
                                               input logic signed [DATA_W-1:0] v);
    set_report_t r;
    int          pos;
    r.status = ST_OK;
    pos = 0;
    case (op)
      OP_INSERT: begin
        if (held_values.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          while (pos < held_values.size() && held_values[pos] < v) pos++;
          if (pos < held_values.size() && held_values[pos] == v) r.status = ST_DUPLICATE;
          else held_values.insert(pos, v);
        end
      end
      OP_DELETE: begin
        while (pos < held_values.size() && held_values[pos] != v) pos++;
        if (pos >= held_values.size()) r.status = ST_NOT_FOUND;
        else held_values.delete(pos);
      end
      OP_CLEAR: begin
        held_values.delete();
      end
      default: begin
      end
    endcase
    r.entry_count = CNT_OUT_W'(held_values.size());
    if (held_values.size() == 0) begin
      r.smallest = '0;
      r.largest  = '0;
    end else begin
      r.smallest = held_values[0];
      r.largest  = held_values[held_values.size()-1];
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    set_report_t got;
    set_report_t want;
    if (rst) begin
      held_values.delete();
      awaited_reports.delete();
      mismatches <= 0;
      pending    <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.status      = rsp.status;
        got.entry_count = rsp.entry_count;
        got.smallest    = rsp.smallest;
        got.largest     = rsp.largest;
        if (awaited_reports.size() == 0) begin
          mismatches <= mismatches + 1;
          $display("%0t: unexpected response beat: status %0d count %0d smallest %0d largest %0d",
                   $time, got.status, got.entry_count, got.smallest, got.largest);
        end else begin
          want = awaited_reports.pop_front();
          if (got.status !== want.status || got.entry_count !== want.entry_count ||
              got.smallest !== want.smallest || got.largest !== want.largest) begin
            mismatches <= mismatches + 1;
            $display("%0t: expected status %0d count %0d smallest %0d largest %0d",
                     $time, want.status, want.entry_count, want.smallest, want.largest);
            $display("%0t: actual   status %0d count %0d smallest %0d largest %0d",
                     $time, got.status, got.entry_count, got.smallest, got.largest);
          end
        end
      end
      if (req.valid && req.ready) begin
        awaited_reports.push_back(apply_set_op(req.operation, req.value));
      end
      pending <= awaited_reports.size();
    end
  end

endmodule

// ===== tb/sorted_unique_set_test.sv =====
`timescale 1ns / 1ps
// sorted_unique_set_test: drives operations into the sorted set and reports the verdict
module sorted_unique_set_test;
  import sus_pkg::*;

  localparam int CAPACITY = CAPACITY_DEFAULT;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1650;
  localparam int BLOCK_ITEMS  = 150;
  localparam int POOL_SIZE    = 24;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic signed [DATA_W-1:0] MIN_VALUE = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MAX_VALUE = 32'sh7fff_ffff;

  logic clk;
  logic rst = 1'b1;
  int   mismatches;
  int   pending;
  int   cycles = 0;
  bit   calm = 1'b0;

  logic signed [DATA_W-1:0] value_pool[POOL_SIZE];

  sus_req_if req();
  sus_rsp_if rsp();

  sorted_unique_set #(.CAPACITY(CAPACITY)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  sorted_unique_set_check #(.CAPACITY(CAPACITY)) u_check (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .mismatches(mismatches),
    .pending(pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic offer_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.value     <= v;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic refresh_pool();
    value_pool[0] = MIN_VALUE;
    value_pool[1] = MAX_VALUE;
    value_pool[2] = 0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    for (int i = 5; i < POOL_SIZE; i++) begin
      if ($urandom_range(0, 1) == 0) value_pool[i] = $signed($urandom_range(0, 40)) - 20;
      else value_pool[i] = $urandom();
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return value_pool[$urandom_range(0, POOL_SIZE-1)];
  endfunction

  // response side: random stalls, plus long hold-offs that back up the request side
  initial begin : drain
    int gap;
    int taken;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == 300 || taken == 1000) begin
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          rsp.ready <= 1'b0;
          do @(posedge clk); while (!rsp.valid);
          repeat (gap - 1) @(posedge clk);
        end
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      taken++;
    end
  end

  initial begin : stimulus
    int                  insert_weight;
    int                  pick;
    logic [OP_W-1:0]     op;
    req.valid     = 1'b0;
    req.operation = OP_INSERT;
    req.value     = '0;
    rsp.ready     = 1'b0;
    refresh_pool();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty set, single entry, extremes, duplicates, full, unused code
    offer_op(OP_DELETE, 5);
    offer_op(OP_INSERT, 0);
    offer_op(OP_DELETE, 7);
    offer_op(OP_DELETE, 0);
    offer_op(OP_INSERT, MAX_VALUE);
    offer_op(OP_INSERT, MIN_VALUE);
    offer_op(OP_INSERT, MIN_VALUE);
    for (int i = 0; i < CAPACITY - 2; i++) offer_op(OP_INSERT, i * 7 - 40);
    offer_op(OP_INSERT, MAX_VALUE);
    offer_op(OP_INSERT, 12345);
    offer_op(OP_DELETE, -5);
    offer_op(OP_DELETE, MIN_VALUE);
    offer_op(OP_DELETE, MAX_VALUE);
    offer_op(OP_UNUSED, -1);
    offer_op(OP_CLEAR, MAX_VALUE);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK_ITEMS == 0) begin
        refresh_pool();
        insert_weight = $urandom_range(40, 70);
        calm = ((n / BLOCK_ITEMS) % 3 == 1);
      end
      pick = $urandom_range(0, 99);
      if (pick < insert_weight) op = OP_INSERT;
      else if (pick < 96) op = OP_DELETE;
      else if (pick < 99) op = OP_CLEAR;
      else op = OP_UNUSED;
      offer_op(op, pick_value());
    end
    req.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
